FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the pixel unpacker.
// The macros expect clk, and TPU_ASSERT also rst_n, to be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TPU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define TPU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/tpu_pkg.sv
// Shared types, register codes and hash helpers for the texture pixel unpacker.
// No dependencies; tpu_cfg_regs, tpu_unpack, tpu_hash_pipe and the top level import it.
package tpu_pkg;

  // Format mode codes.
  localparam logic [3:0] MODE_L8      = 4'd0;
  localparam logic [3:0] MODE_A8      = 4'd1;
  localparam logic [3:0] MODE_R8      = 4'd2;
  localparam logic [3:0] MODE_L8A8    = 4'd3;
  localparam logic [3:0] MODE_R8G8    = 4'd4;
  localparam logic [3:0] MODE_RGBA8   = 4'd5;
  localparam logic [3:0] MODE_BGRA8   = 4'd6;
  localparam logic [3:0] MODE_RGB10A2 = 4'd7;
  localparam logic [3:0] MODE_DEPTH   = 4'd8;
  localparam logic [3:0] MODE_FLOAT   = 4'd9;
  localparam logic [3:0] MODE_SEGHASH = 4'd10;

  // Configuration register indexes.
  localparam logic [1:0] REG_FORMAT_MODE  = 2'd0;
  localparam logic [1:0] REG_FORCE_OPAQUE = 2'd1;
  localparam logic [1:0] REG_DEPTH_KEEP   = 2'd2;
  localparam logic [1:0] REG_FLOAT_SWAP   = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [3:0] RST_FORMAT_MODE = MODE_RGBA8;
  localparam logic [3:0] RST_DEPTH_KEEP  = 4'd3;
  localparam logic [3:0] DEPTH_ALL_BYTES = 4'd8;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Hash constants for a single 4-byte word, seed zero.
  localparam logic [31:0] PRIME32_2 = 32'd2246822519;
  localparam logic [31:0] PRIME32_3 = 32'd3266489917;
  localparam logic [31:0] PRIME32_4 = 32'd668265263;
  localparam logic [31:0] HASH_INIT = 32'd374761397;  // prime 5 plus the length

  // Hash rounds that run in the pipeline after the first multiply.
  localparam int unsigned HASH_STAGES = 3;
  localparam logic [1:0]  ROUND_ROT  = 2'd0;
  localparam logic [1:0]  ROUND_MIX1 = 2'd1;
  localparam logic [1:0]  ROUND_MIX2 = 2'd2;

  typedef struct packed {
    logic [3:0] format_mode;
    logic       force_opaque;
    logic [3:0] depth_bytes_keep;
    logic       float_byte_swap;
  } cfg_t;

  // One pipeline slot: valid bit, finished channels, and the hash in flight.
  typedef struct packed {
    logic        valid;
    logic        hash_sel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] word;
    logic [31:0] hsh;
  } stage_t;

  // One multiply round of the hash; the round code is a constant at each stage.
  function automatic logic [31:0] hash_round(input logic [1:0] round, input logic [31:0] h);
    logic [31:0] s;
    logic [31:0] t;
    logic [31:0] p;
    s = HASH_INIT + h;
    case (round)
      ROUND_ROT: begin
        t = {s[14:0], s[31:15]};
        p = PRIME32_4;
      end
      ROUND_MIX1: begin
        t = h ^ (h >> 15);
        p = PRIME32_2;
      end
      ROUND_MIX2: begin
        t = h ^ (h >> 13);
        p = PRIME32_3;
      end
      default: begin
        t = h;
        p = 32'd1;
      end
    endcase
    return t * p;
  endfunction

endpackage

FILE: rtl/core/tpu_cfg_regs.sv
// Configuration register file of the texture pixel unpacker.
// Depends on tpu_pkg for register indexes, reset values and cfg_t.
module tpu_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tpu_pkg::cfg_t                  cfg
);
  import tpu_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format_mode      <= RST_FORMAT_MODE;
      cfg_r.force_opaque     <= 1'b0;
      cfg_r.depth_bytes_keep <= RST_DEPTH_KEEP;
      cfg_r.float_byte_swap  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT_MODE:  cfg_r.format_mode      <= cfg_wdata;
        REG_FORCE_OPAQUE: cfg_r.force_opaque     <= cfg_wdata[0];
        REG_DEPTH_KEEP:   cfg_r.depth_bytes_keep <= cfg_wdata;
        REG_FLOAT_SWAP:   cfg_r.float_byte_swap  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/tpu_unpack.sv
// First pipeline stage: byte remapping for every format and the first hash multiply.
// Depends on tpu_pkg for format codes, cfg_t and stage_t.
module tpu_unpack (
  input  logic            clk,
  input  logic            rst_n,
  input  tpu_pkg::cfg_t   cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [63:0]     raw_pixel,
  output tpu_pkg::stage_t dn_stage,
  input  logic            dn_ready
);
  import tpu_pkg::*;

  stage_t      st_r;
  stage_t      st_nxt;
  logic [7:0]  b [8];
  logic [3:0]  keep_eff;
  logic [63:0] kept;
  logic [31:0] depth_word;
  logic        load;

  assign load     = !st_r.valid || dn_ready;
  assign up_ready = load;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = raw_pixel[8*i +: 8];
    end
    // A byte count of zero or above eight keeps the whole pixel.
    if (cfg.depth_bytes_keep == 4'd0 || cfg.depth_bytes_keep > DEPTH_ALL_BYTES) begin
      keep_eff = DEPTH_ALL_BYTES;
    end else begin
      keep_eff = cfg.depth_bytes_keep;
    end
    for (int i = 0; i < 8; i++) begin
      kept[8*i +: 8] = (4'(i) < keep_eff) ? b[i] : 8'd0;
    end
    depth_word = (|kept[63:32]) ? 32'hFFFF_FFFF : kept[31:0];
  end

  always_comb begin
    st_nxt       = '0;
    st_nxt.valid = up_valid;
    case (cfg.format_mode)
      MODE_L8: begin
        st_nxt.red   = b[0];
        st_nxt.green = b[0];
        st_nxt.blue  = b[0];
      end
      MODE_A8: begin
        st_nxt.alpha = b[0];
      end
      MODE_R8: begin
        st_nxt.red = b[0];
      end
      MODE_L8A8: begin
        st_nxt.red   = b[0];
        st_nxt.green = b[0];
        st_nxt.blue  = b[0];
        st_nxt.alpha = b[1];
      end
      MODE_R8G8: begin
        st_nxt.red   = b[0];
        st_nxt.green = b[1];
      end
      MODE_RGBA8: begin
        st_nxt.red   = b[0];
        st_nxt.green = b[1];
        st_nxt.blue  = b[2];
        st_nxt.alpha = cfg.force_opaque ? ALPHA_OPAQUE : b[3];
      end
      MODE_BGRA8: begin
        st_nxt.red   = b[2];
        st_nxt.green = b[1];
        st_nxt.blue  = b[0];
        st_nxt.alpha = cfg.force_opaque ? ALPHA_OPAQUE : b[3];
      end
      MODE_RGB10A2: begin
        // Keep the top eight bits of each ten-bit channel.
        st_nxt.red   = raw_pixel[9:2];
        st_nxt.green = raw_pixel[19:12];
        st_nxt.blue  = raw_pixel[29:22];
      end
      MODE_DEPTH: begin
        st_nxt.word = depth_word;
      end
      MODE_FLOAT: begin
        st_nxt.word = cfg.float_byte_swap ? {b[0], b[1], b[2], b[3]} : raw_pixel[31:0];
      end
      MODE_SEGHASH: begin
        st_nxt.hash_sel = 1'b1;
        st_nxt.hsh      = raw_pixel[31:0] * PRIME32_3;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (load) begin
      st_r.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      st_r.hash_sel <= st_nxt.hash_sel;
      st_r.red      <= st_nxt.red;
      st_r.green    <= st_nxt.green;
      st_r.blue     <= st_nxt.blue;
      st_r.alpha    <= st_nxt.alpha;
      st_r.word     <= st_nxt.word;
      st_r.hsh      <= st_nxt.hsh;
    end
  end

  assign dn_stage = st_r;

endmodule

FILE: rtl/core/tpu_hash_pipe.sv
// Three pipelined hash rounds, one multiply per stage, with the finished channels
// riding alongside. Depends on tpu_pkg for stage_t and hash_round.
module tpu_hash_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  tpu_pkg::stage_t up_stage,
  output logic            up_ready,
  output tpu_pkg::stage_t dn_stage,
  input  logic            dn_ready
);
  import tpu_pkg::*;

  stage_t st_r [HASH_STAGES];
  stage_t src  [HASH_STAGES];
  logic   load [HASH_STAGES];

  // A stage takes a new slot when it is empty or its content moves on.
  always_comb begin
    for (int i = 0; i < HASH_STAGES; i++) begin
      src[i] = (i == 0) ? up_stage : st_r[(i == 0) ? 0 : i - 1];
    end
    for (int i = HASH_STAGES - 1; i >= 0; i--) begin
      if (i == HASH_STAGES - 1) begin
        load[i] = !st_r[i].valid || dn_ready;
      end else begin
        load[i] = !st_r[i].valid || load[i + 1];
      end
    end
  end

  assign up_ready = load[0];

  for (genvar g = 0; g < HASH_STAGES; g++) begin : g_round
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[g].valid <= 1'b0;
      end else if (load[g]) begin
        st_r[g].valid <= src[g].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (load[g] && src[g].valid) begin
        st_r[g].hash_sel <= src[g].hash_sel;
        st_r[g].red      <= src[g].red;
        st_r[g].green    <= src[g].green;
        st_r[g].blue     <= src[g].blue;
        st_r[g].alpha    <= src[g].alpha;
        st_r[g].word     <= src[g].word;
        st_r[g].hsh      <= hash_round(2'(g), src[g].hsh);
      end
    end
  end

  assign dn_stage = st_r[HASH_STAGES - 1];

endmodule

FILE: rtl/core/texture_pixel_unpacker_top.sv
// Texture pixel unpacker top level: configuration registers, unpack stage, hash
// pipeline and output register. Depends on tpu_pkg, tpu_cfg_regs, tpu_unpack and
// tpu_hash_pipe.
//
// Usage: raw pixels arrive as 64-bit beats on in_t*, byte 0 in bits 7:0. Each beat
// yields exactly one result beat on out_t*, in order. The format and its options
// are set through the write port cfg_we/cfg_index/cfg_wdata while no beat is in
// flight; a write takes effect on the next clock.
// A beat accepted at a clock edge is loaded into the unpack stage at that edge, then
// passes three hash stages (one 32x32 multiply each) and the output register, which
// drives out_tvalid. All formats pass through the same five registers so results
// leave in order. Throughput is one beat per cycle while out_tready stays high.
// Every stage loads when it is empty or its content moves on, so bubbles are
// squeezed out and a stalled receiver lets the pipe fill before in_tready falls.
// Reset clears all valid bits and loads the register reset values (rgba8 mode,
// depth keep of three bytes, both flags off).
module texture_pixel_unpacker_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // raw_pixel[63:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24], out_word[63:32]
  output logic [63:0]                    out_tdata,
  input  logic                           cfg_we,
  input  logic [tpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tpu_pkg::*;

  cfg_t        cfg;
  stage_t      unp_stage;
  stage_t      hash_stage;
  logic        unp_ready;
  logic        out_load;
  logic [31:0] hash_fin;
  logic [63:0] out_data_nxt;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  tpu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpu_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .raw_pixel (in_tdata),
    .dn_stage  (unp_stage),
    .dn_ready  (unp_ready)
  );

  tpu_hash_pipe u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_stage (unp_stage),
    .up_ready (unp_ready),
    .dn_stage (hash_stage),
    .dn_ready (out_load)
  );

  assign out_load = !out_valid_r || out_tready;

  // Final avalanche shift; hash mode outputs only the hash colors, zeros elsewhere.
  always_comb begin
    hash_fin = hash_stage.hsh ^ (hash_stage.hsh >> 16);
    if (hash_stage.hash_sel) begin
      out_data_nxt = {32'd0, 8'd0, hash_fin[23:16], hash_fin[15:8], hash_fin[7:0]};
    end else begin
      out_data_nxt = {hash_stage.word, hash_stage.alpha, hash_stage.blue,
                      hash_stage.green, hash_stage.red};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= hash_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && hash_stage.valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/tpu_checker.sv
// Port-level checker for the texture pixel unpacker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // A held result beat stays offered and unchanged.
  `TPU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")
  `TPU_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed under stall")

  // Reset empties the pipe, so no result follows a reset cycle.
  `TPU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result beat right after reset")

  // With the output register empty every stage can load, so input is never blocked.
  `TPU_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input blocked with empty output")

endmodule

bind texture_pixel_unpacker_top tpu_checker u_tpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
